/* design/vbs_pkg.sv */
`default_nettype none

package vbs_pkg;

    localparam int unsigned NUM_BONES_DEFAULT = 256;
    localparam int unsigned MAT_WORDS = 12;
    localparam int unsigned MAX_BLEND = 4;

    localparam logic KIND_MATRIX = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ROW,
        ST_WEIGHT,
        ST_DONE
    } vbs_state_t;

    typedef struct packed {
        logic       start;
        logic       busy;
        logic       done;
    } vbs_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -50'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/vertex_blend_skinning.sv */
// A matrix write gives no result. A vertex result is computed by stepping over the 12
// matrix elements of each bone with one multiplier and, for two to four bones, by weighting
// the 3 rows of each bone with a second multiplier. One vertex at a time; the result waits
// in an output register and the next transaction is accepted once it has been taken.
// Reset is asynchronous and active low; the palette is undefined until written.
`default_nettype none

module vertex_blend_skinning #(
    parameter int unsigned NUM_BONES = vbs_pkg::NUM_BONES_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic [31:0]        bones_packed,
    input  wire logic [15:0]        weight_a,
    input  wire logic [15:0]        weight_b,
    input  wire logic [15:0]        weight_c,
    input  wire logic [15:0]        weight_d,
    input  wire logic [2:0]         weight_count,
    input  wire logic [11:0]        matrix_addr,
    input  wire logic signed [31:0] matrix_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z
);
    import vbs_pkg::*;

    vbs_ctrl_t ctrl;
    logic signed [31:0] rx, ry, rz;
    logic in_fire;
    logic out_valid_reg;

    assign in_ready = !ctrl.busy && !out_valid_reg;
    assign in_fire = in_valid && in_ready;

    vbs_core #(
        .NUM_BONES(NUM_BONES),
        .ADDR_W(12)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(in_fire && kind == KIND_MATRIX),
        .wr_addr(matrix_addr),
        .wr_data(matrix_value),
        .start(in_fire && kind == KIND_VERTEX),
        .px(pos_x),
        .py(pos_y),
        .pz(pos_z),
        .bones(bones_packed),
        .weights({weight_d, weight_c, weight_b, weight_a}),
        .count(weight_count),
        .ctrl(ctrl),
        .rx(rx),
        .ry(ry),
        .rz(rz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done)
        begin
            out_x <= rx;
            out_y <= ry;
            out_z <= rz;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.busy |-> !in_ready)
        else $error("transaction accepted while busy");
    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.done |=> out_valid)
        else $error("finished vertex produced no result");
    a_no_start_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !ctrl.start)
        else $error("vertex started while a result waits");

endmodule

`default_nettype wire

/* design/vbs_core.sv */
`default_nettype none

module vbs_core #(
    parameter int unsigned NUM_BONES = vbs_pkg::NUM_BONES_DEFAULT,
    parameter int unsigned ADDR_W = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire logic [31:0]         wr_data,
    input  wire logic                start,
    input  wire logic signed [31:0]  px,
    input  wire logic signed [31:0]  py,
    input  wire logic signed [31:0]  pz,
    input  wire logic [31:0]         bones,
    input  wire logic [63:0]         weights,
    input  wire logic [2:0]          count,
    output vbs_pkg::vbs_ctrl_t       ctrl,
    output logic signed [31:0]       rx,
    output logic signed [31:0]       ry,
    output logic signed [31:0]       rz
);
    import vbs_pkg::*;

    localparam int unsigned DEPTH = NUM_BONES * MAT_WORDS;

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    vbs_state_t state_reg, state_next;
    logic [1:0] bidx_reg, bidx_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic [1:0] last_reg;
    logic       single_reg;
    logic       valid_bone_reg;
    logic signed [31:0] pos_reg [3];
    logic [31:0] bones_reg;
    logic [63:0] wts_reg;
    logic signed [49:0] rowacc_reg;
    logic signed [31:0] t_reg [3];
    logic signed [49:0] acc_reg [3];

    logic [7:0] bone_id;
    logic [3:0] elem;
    logic [ADDR_W+1:0] raddr;
    logic signed [63:0] prod;
    logic signed [47:0] wprod;
    logic [15:0] wcur;

    always_comb
    begin
        bone_id = bones_reg[8*bidx_reg +: 8];
        elem = {row_reg, col_reg};
        raddr = (ADDR_W+2)'(bone_id) * (ADDR_W+2)'(MAT_WORDS) + (ADDR_W+2)'(elem);
        wcur = wts_reg[16*bidx_reg +: 16];
        prod = $signed(rdata_reg) * pos_reg[col_reg];
        wprod = t_reg[row_reg] * $signed({1'b0, wcur});
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(wr_addr) < DEPTH))
        begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == ST_READ)
        begin
            rdata_reg <= (32'(raddr) < DEPTH) ? mem[raddr[ADDR_W-1:0]] : 32'd0;
            valid_bone_reg <= 32'(bone_id) < NUM_BONES;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bidx_next = bidx_reg;
        row_next = row_reg;
        col_next = col_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                    bidx_next = 2'd0;
                    row_next = 2'd0;
                    col_next = 2'd0;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:
            begin
                if (col_reg == 2'd3)
                begin
                    col_next = 2'd0;
                    if (row_reg == 2'd2)
                    begin
                        row_next = 2'd0;
                        state_next = single_reg ? ST_DONE : ST_WEIGHT;
                    end
                    else
                    begin
                        row_next = row_reg + 2'd1;
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                    state_next = ST_READ;
                end
            end
            ST_WEIGHT:
            begin
                if (row_reg == 2'd2)
                begin
                    row_next = 2'd0;
                    if (bidx_reg == last_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        bidx_next = bidx_reg + 2'd1;
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    row_next = row_reg + 2'd1;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bidx_reg <= 2'd0;
            row_reg <= 2'd0;
            col_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            bidx_reg <= bidx_next;
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            pos_reg[0] <= px;
            pos_reg[1] <= py;
            pos_reg[2] <= pz;
            bones_reg <= bones;
            wts_reg <= weights;
            single_reg <= (count <= 3'd1);
            last_reg <= (count == 3'd0) ? 2'd0 : (count > 3'd4) ? 2'd3 : 2'(count - 3'd1);
            rowacc_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_MUL)
        begin
            if (col_reg == 2'd3)
            begin
                t_reg[row_reg] <= sat32(valid_bone_reg
                    ? rowacc_reg + 50'($signed(rdata_reg)) : 50'sd0);
                rowacc_reg <= '0;
            end
            else
            begin
                rowacc_reg <= rowacc_reg + 50'(prod >>> 16);
            end
        end
        else if (state_reg == ST_WEIGHT)
        begin
            acc_reg[row_reg] <= acc_reg[row_reg] + 50'(wprod >>> 15);
        end
    end

    always_comb
    begin
        ctrl.start = start && state_reg == ST_IDLE;
        ctrl.busy = state_reg != ST_IDLE;
        ctrl.done = state_reg == ST_DONE;
        rx = single_reg ? t_reg[0] : sat32(acc_reg[0]);
        ry = single_reg ? t_reg[1] : sat32(acc_reg[1]);
        rz = single_reg ? t_reg[2] : sat32(acc_reg[2]);
    end

endmodule

`default_nettype wire

/* dv/tb_vertex_blend_skinning.sv */
`timescale 1ns / 100ps

module tb_vertex_blend_skinning;
    import vbs_pkg::*;

    localparam int unsigned PALETTE_WORDS = NUM_BONES_DEFAULT * MAT_WORDS;
    localparam int unsigned ITEM_TARGET = 750;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    typedef struct {
        logic               kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        bones_packed;
        logic [15:0]        weight_a;
        logic [15:0]        weight_b;
        logic [15:0]        weight_c;
        logic [15:0]        weight_d;
        logic [2:0]         weight_count;
        logic [11:0]        matrix_addr;
        logic signed [31:0] matrix_value;
    } skin_item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } skinned_pos_t;

    class skin_scoreboard;
        logic [31:0]  palette [PALETTE_WORDS];
        skinned_pos_t expected_q [$];
        int unsigned  fails;

        function new();
            fails = 0;
            foreach (palette[i])
            begin
                palette[i] = '0;
            end
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void transform_bone(int unsigned bone, longint p [3], output longint t [3]);
            longint acc;
            longint m;
            for (int r = 0; r < 3; r++)
            begin
                acc = 0;
                for (int c = 0; c < 3; c++)
                begin
                    m = $signed(palette[bone * MAT_WORDS + r * 4 + c]);
                    acc += (m * p[c]) >>> 16;
                end
                m = $signed(palette[bone * MAT_WORDS + r * 4 + 3]);
                acc += m;
                t[r] = clamp32(acc);
            end
        endfunction

        function void note_input(skin_item_t it);
            longint       p [3];
            longint       t [3];
            longint       acc [3];
            longint       w [4];
            int unsigned  cnt;
            skinned_pos_t res;
            if (it.kind == KIND_MATRIX)
            begin
                if (it.matrix_addr < PALETTE_WORDS)
                begin
                    palette[it.matrix_addr] = it.matrix_value;
                end
                return;
            end
            p[0] = it.pos_x;
            p[1] = it.pos_y;
            p[2] = it.pos_z;
            w[0] = it.weight_a;
            w[1] = it.weight_b;
            w[2] = it.weight_c;
            w[3] = it.weight_d;
            cnt = it.weight_count;
            if (cnt == 0)
            begin
                cnt = 1;
            end
            if (cnt > MAX_BLEND)
            begin
                cnt = MAX_BLEND;
            end
            if (cnt == 1)
            begin
                transform_bone(it.bones_packed[7:0], p, acc);
            end
            else
            begin
                acc[0] = 0;
                acc[1] = 0;
                acc[2] = 0;
                for (int j = 0; j < cnt; j++)
                begin
                    transform_bone(it.bones_packed[8 * j +: 8], p, t);
                    for (int r = 0; r < 3; r++)
                    begin
                        acc[r] += (t[r] * w[j]) >>> 15;
                    end
                end
                for (int r = 0; r < 3; r++)
                begin
                    acc[r] = clamp32(acc[r]);
                end
            end
            res.x = acc[0][31:0];
            res.y = acc[1][31:0];
            res.z = acc[2][31:0];
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z);
            skinned_pos_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result x=%0d y=%0d z=%0d", x, y, z);
                fails++;
                return;
            end
            e = expected_q.pop_front();
            if (x !== e.x)
            begin
                $error("out_x: expected %0d, got %0d", e.x, x);
                fails++;
            end
            if (y !== e.y)
            begin
                $error("out_y: expected %0d, got %0d", e.y, y);
                fails++;
            end
            if (z !== e.z)
            begin
                $error("out_z: expected %0d, got %0d", e.z, z);
                fails++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        bones_packed;
    logic [15:0]        weight_a;
    logic [15:0]        weight_b;
    logic [15:0]        weight_c;
    logic [15:0]        weight_d;
    logic [2:0]         weight_count;
    logic [11:0]        matrix_addr;
    logic signed [31:0] matrix_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;

    skin_scoreboard sb;
    int unsigned    items_sent;
    int unsigned    hold_left;
    int unsigned    idle_cycles;
    bit             no_gaps;
    bit [255:0]     bone_loaded;
    int unsigned    loaded_bones [$];

    vertex_blend_skinning u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .bones_packed (bones_packed),
        .weight_a     (weight_a),
        .weight_b     (weight_b),
        .weight_c     (weight_c),
        .weight_d     (weight_d),
        .weight_count (weight_count),
        .matrix_addr  (matrix_addr),
        .matrix_value (matrix_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic send_item(skin_item_t it);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        kind         <= it.kind;
        pos_x        <= it.pos_x;
        pos_y        <= it.pos_y;
        pos_z        <= it.pos_z;
        bones_packed <= it.bones_packed;
        weight_a     <= it.weight_a;
        weight_b     <= it.weight_b;
        weight_c     <= it.weight_c;
        weight_d     <= it.weight_d;
        weight_count <= it.weight_count;
        matrix_addr  <= it.matrix_addr;
        matrix_value <= it.matrix_value;
        in_valid     <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && in_ready));
        sb.note_input(it);
        items_sent++;
    endtask

    function automatic skin_item_t random_item();
        skin_item_t it;
        it.kind         = 1'($urandom_range(0, 1));
        it.pos_x        = $urandom;
        it.pos_y        = $urandom;
        it.pos_z        = $urandom;
        it.bones_packed = $urandom;
        it.weight_a     = 16'($urandom);
        it.weight_b     = 16'($urandom);
        it.weight_c     = 16'($urandom);
        it.weight_d     = 16'($urandom);
        it.weight_count = 3'($urandom);
        it.matrix_addr  = 12'($urandom);
        it.matrix_value = $urandom;
        return it;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $urandom;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    task automatic write_element(int unsigned addr, logic signed [31:0] value);
        skin_item_t it;
        it = random_item();
        it.kind = KIND_MATRIX;
        it.matrix_addr = 12'(addr);
        it.matrix_value = value;
        send_item(it);
    endtask

    task automatic load_bone(int unsigned bone);
        for (int e = 0; e < MAT_WORDS; e++)
        begin
            write_element(bone * MAT_WORDS + e, pick_value());
        end
        if (!bone_loaded[bone])
        begin
            bone_loaded[bone] = 1'b1;
            loaded_bones.insert(loaded_bones.size(), bone);
        end
    endtask

    task automatic send_vertex(logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [31:0] pz, logic [31:0] bones,
                               logic [15:0] wa, logic [15:0] wb, logic [15:0] wc,
                               logic [15:0] wd, logic [2:0] cnt);
        skin_item_t it;
        it = random_item();
        it.kind = KIND_VERTEX;
        it.pos_x = px;
        it.pos_y = py;
        it.pos_z = pz;
        it.bones_packed = bones;
        it.weight_a = wa;
        it.weight_b = wb;
        it.weight_c = wc;
        it.weight_d = wd;
        it.weight_count = cnt;
        send_item(it);
    endtask

    task automatic random_vertex();
        logic [31:0] bones;
        logic [15:0] w [4];
        bones = $urandom;
        for (int j = 0; j < 4; j++)
        begin
            bones[8 * j +: 8] = 8'(loaded_bones[$urandom_range(0, loaded_bones.size() - 1)]);
            w[j] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        end
        send_vertex(pick_value(), pick_value(), pick_value(), bones,
                    w[0], w[1], w[2], w[3], 3'($urandom));
    endtask

    initial
    begin
        sb = new();
        items_sent = 0;
        hold_left = 0;
        no_gaps = 1'b0;
        bone_loaded = '0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        kind <= KIND_MATRIX;
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
        bones_packed <= '0;
        weight_a <= '0;
        weight_b <= '0;
        weight_c <= '0;
        weight_d <= '0;
        weight_count <= '0;
        matrix_addr <= '0;
        matrix_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_element(0, 32'sh0001_0000);
        write_element(1, 32'sh7fffffff);
        write_element(2, 32'sh80000000);
        write_element(3, 32'sh0000_0003);
        write_element(4, 32'shffff_0000);
        write_element(5, 32'sh0);
        write_element(6, 32'sh0002_0000);
        write_element(7, 32'sh80000000);
        write_element(8, 32'sh1234_5678);
        write_element(9, 32'shedcb_a987);
        write_element(10, 32'sh0000_8000);
        write_element(11, 32'sh7fffffff);
        bone_loaded[0] = 1'b1;
        loaded_bones.insert(loaded_bones.size(), 0);
        // Writes above the palette are dropped by the block.
        write_element(4095, 32'sh5555_aaaa);
        write_element(PALETTE_WORDS, 32'shaaaa_5555);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0, 0, 1);
        send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 16'hffff, 0, 0, 0, 0);
        send_vertex(0, 0, 0, 0, 32768, 32768, 0, 0, 2);
        send_vertex(32'sh0001_0000, 32'shffff_0000, 32'sh0003_8000, 0,
                    16'hffff, 0, 1, 0, 3);
        send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh0000_0001, 0,
                    32768, 32768, 32768, 32768, 4);
        send_vertex(32'sh0002_0000, 32'sh0005_0000, 32'shfff0_0000, 0,
                    16384, 8192, 4096, 4096, 5);
        send_vertex(32'sh0010_0000, 32'sh0, 32'sh80000000, 0,
                    16'hffff, 16'hffff, 16'hffff, 16'hffff, 7);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > 250 && items_sent < 262)
            begin
                hold_left = HOLD_CYCLES;
            end
            if (items_sent > 500 && items_sent < 512)
            begin
                if (sb.pending() != 0)
                begin
                    in_valid <= 1'b0;
                    while (sb.pending() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
            no_gaps = (items_sent > 320 && items_sent < 420);
            case ($urandom_range(0, 9))
                0:
                begin
                    load_bone($urandom_range(0, 255));
                end
                1:
                begin
                    write_element($urandom_range(PALETTE_WORDS, 4095), $urandom);
                end
                default:
                begin
                    if (loaded_bones.size() < 3)
                    begin
                        load_bone($urandom_range(0, 255));
                    end
                    else
                    begin
                        random_vertex();
                    end
                end
            endcase
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fails == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_result(out_x, out_y, out_z);
                stall_left = no_gaps ? 0 : $urandom_range(0, 6);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
design/vbs_pkg.sv
design/vbs_core.sv
design/vertex_blend_skinning.sv
dv/tb_vertex_blend_skinning.sv
